[rtl/core/strict_base64_decoder_top_macros.svh]
// Assertion macros for the strict base64 decoder checker.
// Depends on nothing; included by the checker file only.
`ifndef STRICT_BASE64_DECODER_TOP_MACROS_SVH
`define STRICT_BASE64_DECODER_TOP_MACROS_SVH

// A property checked outside reset.
`define SBD_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// A property that also holds while reset is applied.
`define SBD_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[rtl/core/sbd_pkg.sv]
// Shared types, constants and the alphabet lookup of the strict base64 decoder.
// Depends on nothing; used by sbd_decode, sbd_out, the top level and the testbench.
`default_nettype none

package sbd_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned ACC_W   = 18;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [5:0] SEXTET_LC    = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;

  typedef struct packed {
    logic              string_end;
    logic              failed;
    logic [COUNT_W-1:0] byte_count;
    logic [CHAR_W-1:0]  out_byte;
  } result_t;

  typedef struct packed {
    logic [1:0]        n;
    result_t [2:0]     res;
  } bundle_t;

  // Bit 6 set means the byte is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - CHAR_UC_A)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - CHAR_LC_A) + SEXTET_LC};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - CHAR_ZERO) + SEXTET_DIGIT};
    end else if (c == CHAR_PLUS) begin
      r = {1'b0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b0, SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sbd_decode.sv]
// Input register, group state and decode logic of the strict base64 decoder.
// Depends on sbd_pkg; produces one result bundle per completed group or fault.
`default_nettype none

module sbd_decode #(
  parameter int unsigned MAX_CAPACITY = 4095
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sbd_pkg::COUNT_W-1:0]   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sbd_pkg::CHAR_W-1:0]    in_char,
  input  wire logic                          in_final,
  input  wire logic                          bundle_free,
  output logic                               push,
  output sbd_pkg::bundle_t                   bundle
);

  localparam logic [15:0] MAX_CAP = MAX_CAPACITY[15:0];

  logic                          v_r, v_nxt;
  logic [sbd_pkg::CHAR_W-1:0]    char_r;
  logic                          fin_r;
  logic [1:0]                    pos_r, pos_nxt;
  logic [sbd_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic                          pad_r, pad_nxt;
  logic [sbd_pkg::COUNT_W-1:0]   used_r, used_nxt;
  logic                          disc_r, disc_nxt;
  logic [sbd_pkg::COUNT_W-1:0]   cap_r;

  logic [6:0]  sx;
  logic        invalid;
  logic        is_pad;
  logic        bad;
  logic        emit;
  logic [1:0]  cnt;
  logic [5:0]  vv;
  logic [12:0] sum;
  logic [15:0] cap16;
  logic [15:0] lim16;
  logic [23:0] word;
  logic [1:0]  nres;
  logic        adv;

  assign sx      = sbd_pkg::sextet_of(char_r);
  assign invalid = sx[6];
  assign is_pad  = (char_r == sbd_pkg::CHAR_PAD);
  assign cap16   = {4'b0, cap_r};
  assign lim16   = (cap16 < MAX_CAP) ? cap16 : MAX_CAP;

  always_comb begin
    bad      = 1'b0;
    emit     = 1'b0;
    cnt      = 2'd3;
    vv       = sx[5:0];
    sum      = 13'd0;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    pad_nxt  = pad_r;
    used_nxt = used_r;
    disc_nxt = disc_r;
    if (disc_r) begin
      if (fin_r) begin
        disc_nxt = 1'b0;
        pos_nxt  = 2'd0;
        acc_nxt  = '0;
        pad_nxt  = 1'b0;
        used_nxt = '0;
      end
    end else begin
      case (pos_r)
        2'd0, 2'd1: begin
          if (invalid || fin_r) begin
            bad = 1'b1;
          end else begin
            acc_nxt = {acc_r[11:0], vv};
          end
          pos_nxt = pos_r + 2'd1;
        end
        2'd2: begin
          if (is_pad) begin
            if (acc_r[3:0] != 4'h0) begin
              bad = 1'b1;
            end
            pad_nxt = 1'b1;
            vv      = 6'd0;
          end else if (invalid) begin
            bad = 1'b1;
          end
          if (fin_r) begin
            bad = 1'b1;
          end
          if (!bad) begin
            acc_nxt = {acc_r[11:0], vv};
          end
          pos_nxt = 2'd3;
        end
        default: begin
          if (is_pad) begin
            if (!fin_r) begin
              bad = 1'b1;
            end
            if (!pad_r && (acc_r[1:0] != 2'd0)) begin
              bad = 1'b1;
            end
            cnt = pad_r ? 2'd1 : 2'd2;
            vv  = 6'd0;
          end else if (invalid || pad_r) begin
            bad = 1'b1;
          end
          sum = {1'b0, used_r} + {11'b0, cnt};
          if (!bad && ({3'b0, sum} > lim16)) begin
            bad = 1'b1;
          end
          if (!bad) begin
            emit     = 1'b1;
            pos_nxt  = 2'd0;
            acc_nxt  = '0;
            pad_nxt  = 1'b0;
            used_nxt = fin_r ? '0 : sum[11:0];
          end
        end
      endcase
      if (bad) begin
        pos_nxt  = 2'd0;
        acc_nxt  = '0;
        pad_nxt  = 1'b0;
        used_nxt = '0;
        disc_nxt = !fin_r;
      end
    end
  end

  assign word = {acc_r, vv};

  always_comb begin
    bundle = '0;
    if (bad) begin
      bundle.n                 = 2'd1;
      bundle.res[0].failed     = 1'b1;
      bundle.res[0].string_end = 1'b1;
    end else begin
      bundle.n                 = cnt;
      bundle.res[0].out_byte   = word[23:16];
      bundle.res[0].byte_count = used_r + 12'd1;
      bundle.res[0].string_end = fin_r && (cnt == 2'd1);
      bundle.res[1].out_byte   = word[15:8];
      bundle.res[1].byte_count = used_r + 12'd2;
      bundle.res[1].string_end = fin_r && (cnt == 2'd2);
      bundle.res[2].out_byte   = word[7:0];
      bundle.res[2].byte_count = used_r + 12'd3;
      bundle.res[2].string_end = fin_r && (cnt == 2'd3);
    end
  end

  assign nres      = (!disc_r && bad) ? 2'd1 : ((!disc_r && emit) ? cnt : 2'd0);
  assign adv       = v_r && ((nres == 2'd0) || bundle_free);
  assign push      = adv && (nres != 2'd0);
  assign in_tready = !v_r || adv;
  assign v_nxt     = (in_tvalid && in_tready) ? 1'b1 : (adv ? 1'b0 : v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      pos_r  <= 2'd0;
      acc_r  <= '0;
      pad_r  <= 1'b0;
      used_r <= '0;
      disc_r <= 1'b0;
      cap_r  <= {sbd_pkg::COUNT_W{1'b1}};
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (adv) begin
        pos_r  <= pos_nxt;
        acc_r  <= acc_nxt;
        pad_r  <= pad_nxt;
        used_r <= used_nxt;
        disc_r <= disc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_char;
      fin_r  <= in_final;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sbd_out.sv]
// Result register of the strict base64 decoder: holds one bundle and hands out its results.
// Depends on sbd_pkg; fed by sbd_decode.
`default_nettype none

module sbd_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sbd_pkg::bundle_t   bundle,
  output logic                    bundle_free,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output sbd_pkg::result_t        head
);

  logic [1:0]               rem_r, rem_nxt;
  sbd_pkg::result_t [2:0]   res_r;
  logic                     xfer;

  assign out_tvalid  = (rem_r != 2'd0);
  assign xfer        = out_tvalid && out_tready;
  assign bundle_free = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_tready);
  assign head        = res_r[0];

  always_comb begin
    rem_nxt = rem_r;
    if (push) begin
      rem_nxt = bundle.n;
    end else if (xfer) begin
      rem_nxt = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= bundle.res;
    end else if (xfer) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

endmodule

`default_nettype wire

[rtl/core/strict_base64_decoder_top.sv]
// Strict base64 decoder: one character in per transfer, decoded bytes out one per transfer.
// A group's last character is registered; its results are then held in sbd_out until all are sent.
// Throughput: one character per cycle, but a group's last character waits until the result register is free.
// Reset: synchronous, active low; clears all group state and sets the capacity to 4095.
// Depends on sbd_pkg, sbd_decode and sbd_out.
`default_nettype none

module strict_base64_decoder_top #(
  parameter int unsigned MAX_CAPACITY = 4095
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [11:0]  cfg_wdata,  // out_capacity
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // in_char
  input  wire logic         in_tlast,   // is_final
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,  // out_byte [7:0], byte_count [19:8], zero fill
  output logic              out_tuser,  // failed
  output logic              out_tlast   // string_end
);

  logic               bundle_free;
  logic               push;
  sbd_pkg::bundle_t   bundle;
  sbd_pkg::result_t   head;

  sbd_decode #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_char    (in_tdata),
    .in_final   (in_tlast),
    .bundle_free(bundle_free),
    .push       (push),
    .bundle     (bundle)
  );

  sbd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .bundle     (bundle),
    .bundle_free(bundle_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {4'b0, head.byte_count, head.out_byte};
  assign out_tuser = head.failed;
  assign out_tlast = head.string_end;

endmodule

`default_nettype wire

[rtl/core/sbd_checker.sv]
// Port-level checker of the strict base64 decoder, bound to the top level.
// Depends on strict_base64_decoder_top_macros.svh and strict_base64_decoder_top.
`default_nettype none
`include "strict_base64_decoder_top_macros.svh"

module sbd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [23:0]  out_tdata,
  input wire logic         out_tuser,
  input wire logic         out_tlast
);

  `SBD_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `SBD_ASSERT(a_fail_end, clk, rst_n, out_tvalid && out_tuser |-> out_tlast && (out_tdata == 24'h0), "error result is not a zero final transfer")
  `SBD_ASSERT(a_count, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[19:8] != 12'h0, "decoded byte with zero count")
  `SBD_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_tvalid && in_tready, "result or stall after reset")

endmodule

bind strict_base64_decoder_top sbd_checker u_sbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of strict_base64_decoder_top: base64 strings in, decoded bytes out.
// A small scoreboard class predicts every result transfer; depends on sbd_pkg and the RTL.

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned STALL_CYCLES = 300;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum int unsigned {
    FAULT_BYTE,
    FAULT_PAD,
    FAULT_TRUNCATE,
    FAULT_LEFTOVER,
    FAULT_EXTEND
  } text_fault_t;

  class base64_scoreboard_t;
    logic [11:0]       capacity;
    logic [1:0]        group_pos;
    logic [17:0]       sextets;
    logic              pad_seen;
    logic [11:0]       bytes_used;
    logic              discarding;
    sbd_pkg::result_t  expected_q[$];
    int unsigned       errors;

    function new();
      capacity = 12'd4095;
      discarding = 1'b0;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      group_pos = 2'd0;
      sextets = '0;
      pad_seen = 1'b0;
      bytes_used = '0;
    endfunction

    // Bit 6 is set for a byte outside the alphabet.
    function logic [6:0] sextet_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
      if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
      if (c == "+") return 7'd62;
      if (c == "/") return 7'd63;
      return 7'h40;
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      logic [6:0]        v;
      logic              is_pad;
      logic              bad;
      int                count;
      logic [23:0]       word;
      sbd_pkg::result_t  r;
      v = sextet_value(c);
      is_pad = (c == PAD_CHAR);
      bad = 1'b0;
      count = 3;
      if (discarding) begin
        if (fin) begin
          discarding = 1'b0;
          clear_string();
        end
        return;
      end
      if (group_pos < 2'd2) begin
        if (v[6] || fin) bad = 1'b1;
        else sextets = {sextets[11:0], v[5:0]};
        group_pos = group_pos + 2'd1;
      end else if (group_pos == 2'd2) begin
        if (is_pad) begin
          if (sextets[3:0] != 4'd0) bad = 1'b1;
          pad_seen = 1'b1;
          v = '0;
        end else if (v[6]) begin
          bad = 1'b1;
        end
        if (fin) bad = 1'b1;
        if (!bad) sextets = {sextets[11:0], v[5:0]};
        group_pos = 2'd3;
      end else begin
        if (is_pad) begin
          if (!fin) bad = 1'b1;
          if (!pad_seen && sextets[1:0] != 2'd0) bad = 1'b1;
          count = pad_seen ? 1 : 2;
          v = '0;
        end else if (v[6] || pad_seen) begin
          bad = 1'b1;
        end
        if (!bad && int'(bytes_used) + count > int'(capacity)) bad = 1'b1;
        if (!bad) begin
          word = {sextets, v[5:0]};
          for (int k = 0; k < count; k++) begin
            bytes_used = bytes_used + 12'd1;
            r.out_byte = word[23 - 8 * k -: 8];
            r.byte_count = bytes_used;
            r.failed = 1'b0;
            r.string_end = fin && (k + 1 == count);
            expected_q.push_back(r);
          end
          group_pos = 2'd0;
          sextets = '0;
          pad_seen = 1'b0;
          if (fin) bytes_used = '0;
          return;
        end
      end
      if (bad) begin
        r.out_byte = '0;
        r.byte_count = '0;
        r.failed = 1'b1;
        r.string_end = 1'b1;
        expected_q.push_back(r);
        clear_string();
        discarding = !fin;
      end
    endfunction

    function void check_result(sbd_pkg::result_t got);
      sbd_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("Unexpected result transfer: out_byte %0d, byte_count %0d",
               got.out_byte, got.byte_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
        errors++;
      end
      if (got.failed !== want.failed) begin
        $error("failed: expected %0d, actual %0d", want.failed, got.failed);
        errors++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %0d, actual %0d", want.string_end, got.string_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  base64_scoreboard_t board;
  int unsigned        cycle_count = 0;
  int unsigned        items_sent = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  logic               stall_request = 1'b0;
  logic [7:0]         text_q[$];

  strict_base64_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) board.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        board.check_result({out_tlast, out_tuser, out_tdata[19:8], out_tdata[7:0]});
      end
    end
  end

  // The receiver holds off for a long stretch once asked, so that the block backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] alphabet_char(input int unsigned v);
    if (v < 26) return 8'(v) + "A";
    if (v < 52) return 8'(v - 26) + "a";
    if (v < 62) return 8'(v - 52) + "0";
    return (v == 62) ? "+" : "/";
  endfunction

  function automatic void build_valid_text();
    int unsigned groups;
    int unsigned pads;
    int unsigned n;
    groups = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(3, 1);
    pads = $urandom_range(2);
    text_q.delete();
    repeat (groups * 4) text_q.push_back(alphabet_char($urandom_range(63)));
    n = text_q.size();
    if (pads == 1) begin
      text_q[n - 1] = PAD_CHAR;
      text_q[n - 2] = alphabet_char($urandom_range(15) * 4);
    end else if (pads == 2) begin
      text_q[n - 1] = PAD_CHAR;
      text_q[n - 2] = PAD_CHAR;
      text_q[n - 3] = alphabet_char($urandom_range(3) * 16);
    end
  endfunction

  function automatic void spoil_text();
    text_fault_t kind;
    int          pad_pos;
    kind = text_fault_t'($urandom_range(4));
    case (kind)
      FAULT_BYTE: begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
      FAULT_PAD: begin
        text_q.insert($urandom_range(text_q.size() - 1), PAD_CHAR);
      end
      FAULT_TRUNCATE: begin
        text_q.delete(text_q.size() - 1);
      end
      FAULT_LEFTOVER: begin
        pad_pos = -1;
        foreach (text_q[i]) if (pad_pos < 0 && text_q[i] == PAD_CHAR) pad_pos = i;
        if (pad_pos > 0) text_q[pad_pos - 1] = alphabet_char($urandom_range(63));
        else text_q[$urandom_range(text_q.size() - 1)] = PAD_CHAR;
      end
      default: begin
        text_q.push_back(alphabet_char($urandom_range(63)));
      end
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_q();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  // The task waits on the clock first so that the last accepted character has been predicted.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [11:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.capacity = value;
  endtask

  task automatic send_random_strings(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 92) begin
        build_valid_text();
        if (pick >= 70) spoil_text();
      end else begin
        text_q.delete();
        repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255)));
      end
      send_text_q();
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 56;
    write_capacity(12'd4095);
    send_text("TWFu////");
    send_text("TWE=");
    send_text("TQ==");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("TQ=");
    send_text("TR==");
    send_random_strings(56);
    write_capacity(12'd0);
    send_random_strings(56);

    send_idle_pct = 56;
    recv_idle_pct = 37;
    write_capacity(12'd3);
    send_random_strings(56);
    write_capacity(12'($urandom_range(12, 4)));
    send_random_strings(56);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(12'($urandom_range(40, 13)));
    stall_request = 1'b1;
    send_random_strings(56);
    write_capacity(12'd4095);
    send_random_strings(56);

    wait_drained();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
